// ----- hdl/sparse_group_segment_sum_assert.svh -----
// Assertion macros for the segment-sum block.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef SPARSE_GROUP_SEGMENT_SUM_ASSERT_SVH
`define SPARSE_GROUP_SEGMENT_SUM_ASSERT_SVH

`ifndef SYNTH
`define SGSS_ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define SGSS_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define SGSS_ASSERT_ALWAYS(name, expr)
`define SGSS_ASSERT_IMPLIES(name, ante, cons)
`endif

`endif

// ----- hdl/sgss_pkg.sv -----
// Shared types and codes for the segment-sum block.
// No dependencies; imported by every module of the block.
package sgss_pkg;

    localparam logic [1:0] OP_LOAD_LABEL = 2'd0;
    localparam logic [1:0] OP_ADD        = 2'd1;
    localparam logic [1:0] OP_READ       = 2'd2;

    localparam int VALUE_W     = 32;
    localparam int SUM_W       = 48;
    localparam int LABEL_W     = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    typedef enum logic [1:0] {
        KIND_ADD       = 2'd0,
        KIND_READ      = 2'd1,
        KIND_READ_NULL = 2'd2
    } kind_t;

    localparam int KIND_W = 2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [11:0]        row;
        logic [5:0]         column;
        logic [5:0]         group;
        logic [6:0]         label;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [47:0] sum;
        logic               saturated;
    } res_t;

    typedef struct packed {
        logic empty;
        logic nearly_full;
    } q_stat_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

endpackage

// ----- hdl/sparse_group_segment_sum.sv -----
// Top level of the group-by segment sum block.
// Depends on sgss_pkg, sgss_front, sgss_queue and sgss_back.
//
// Usage:
//   Request channel: a request is taken at a clock edge with start high and
//   busy low. Operation 0 loads a row label, 1 adds a nonzero into the
//   accumulator of (label-1, column), 2 reads and clears one accumulator.
//   Config channel: cfg_data is num_groups, written when cfg_valid and
//   cfg_ready are high (cfg_ready is always high); write only while idle.
//   Results: a read yields one result on result for exactly one cycle, marked
//   by done. The receiver cannot stall; no back-pressure exists.
//   Read path: front-end stage registers, queue slot, back end entry and read
//   registers, then done and result. Label loads complete at acceptance.
//   Back end: each add or read does its read-modify-write through the idle and
//   apply states before the next; busy rises when the queue is nearly full.
//   Reset: a clearing pass zeroes all MAX_GROUPS*MAX_COLS accumulators, one per
//   cycle; busy stays high until it ends.
module sparse_group_segment_sum
    import sgss_pkg::*;
#(
    parameter int MAX_ROWS   = 4096,
    parameter int MAX_GROUPS = 64,
    parameter int MAX_COLS   = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  req_t       request,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_data,
    output logic       done,
    output res_t       result
);

    localparam int ACC_DEPTH = MAX_GROUPS * MAX_COLS;
    localparam int ACC_AW    = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
    localparam int ENTRY_W   = KIND_W + ACC_AW + VALUE_W;

    q_stat_t            q_stat;
    back_stat_t         b_stat;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] push_data;
    logic [ENTRY_W-1:0] head;

    sgss_front #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_GROUPS (MAX_GROUPS),
        .MAX_COLS   (MAX_COLS),
        .ACC_AW     (ACC_AW),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .b_stat    (b_stat),
        .push      (push),
        .entry     (push_data)
    );

    sgss_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    sgss_back #(
        .ACC_DEPTH (ACC_DEPTH),
        .ACC_AW    (ACC_AW),
        .ENTRY_W   (ENTRY_W)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .b_stat (b_stat),
        .done   (done),
        .result (result)
    );

endmodule

// ----- hdl/sgss_front.sv -----
// Front end: request handshake, num_groups register, row label table, classification.
// Depends on sgss_pkg; feeds sgss_queue with classified entries.
module sgss_front
    import sgss_pkg::*;
#(
    parameter int MAX_ROWS   = 4096,
    parameter int MAX_GROUPS = 64,
    parameter int MAX_COLS   = 64,
    parameter int ACC_AW     = 12,
    parameter int ENTRY_W    = KIND_W + ACC_AW + VALUE_W
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  req_t               request,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [6:0]         cfg_data,
    input  q_stat_t            q_stat,
    input  back_stat_t         b_stat,
    output logic               push,
    output logic [ENTRY_W-1:0] entry
);

    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    typedef struct packed {
        kind_t                     kind;
        logic [ACC_AW-1:0]         index;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    logic [LABEL_W-1:0] label_mem [MAX_ROWS];
    logic [LABEL_W-1:0] lbl_q_reg;

    logic [6:0]                num_groups_reg;
    logic                      s1_valid_reg, s1_valid_next;
    kind_t                     s1_kind_reg, s1_kind_next;
    logic [ACC_AW-1:0]         s1_index_reg, s1_index_next;
    logic [5:0]                s1_col_reg;
    logic signed [VALUE_W-1:0] s1_value_reg;

    logic        accept;
    logic [31:0] row_ext;
    logic        row_ok, col_ok, grp_ok;
    logic [31:0] read_idx;
    logic [31:0] add_idx;
    logic        label_ok;
    entry_t      ent;

    assign accept    = start && !busy;
    assign busy      = b_stat.clearing || q_stat.nearly_full;
    assign cfg_ready = 1'b1;

    assign row_ext  = 32'(request.row);
    assign row_ok   = row_ext < 32'(MAX_ROWS);
    assign col_ok   = 32'(request.column) < 32'(MAX_COLS);
    assign grp_ok   = 32'(request.group) < 32'(MAX_GROUPS);
    assign read_idx = 32'(request.group) * 32'(MAX_COLS) + 32'(request.column);

    always_comb
    begin
        s1_valid_next = 1'b0;
        s1_kind_next  = KIND_ADD;
        s1_index_next = read_idx[ACC_AW-1:0];
        if (accept)
        begin
            case (request.operation)
                OP_ADD:
                begin
                    s1_valid_next = row_ok && col_ok;
                    s1_kind_next  = KIND_ADD;
                end
                OP_READ:
                begin
                    s1_valid_next = 1'b1;
                    s1_kind_next  = (grp_ok && col_ok) ? KIND_READ : KIND_READ_NULL;
                end
                default:
                begin
                    s1_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && request.operation == OP_LOAD_LABEL && row_ok)
        begin
            label_mem[row_ext[ROW_AW-1:0]] <= request.label;
        end
        lbl_q_reg <= label_mem[row_ext[ROW_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_groups_reg <= 7'd64;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                num_groups_reg <= cfg_data;
            end
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg  <= s1_kind_next;
            s1_index_reg <= s1_index_next;
            s1_col_reg   <= request.column;
            s1_value_reg <= request.value;
        end
    end

    // label is one-based; valid when 1..min(num_groups, MAX_GROUPS)
    assign label_ok = (lbl_q_reg != '0)
                   && (lbl_q_reg <= num_groups_reg)
                   && (32'(lbl_q_reg) <= 32'(MAX_GROUPS));
    assign add_idx  = (32'(lbl_q_reg) - 32'd1) * 32'(MAX_COLS) + 32'(s1_col_reg);

    always_comb
    begin
        ent.kind  = s1_kind_reg;
        ent.index = (s1_kind_reg == KIND_ADD) ? add_idx[ACC_AW-1:0] : s1_index_reg;
        ent.value = s1_value_reg;
    end

    assign push  = s1_valid_reg && ((s1_kind_reg != KIND_ADD) || label_ok);
    assign entry = ent;

endmodule

// ----- hdl/sgss_queue.sv -----
// Short request queue between front and back ends.
// Depends on sgss_pkg and the assertion macro header.
`include "sparse_group_segment_sum_assert.svh"

module sgss_queue
    import sgss_pkg::*;
#(
    parameter int ENTRY_W = 46
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [ENTRY_W-1:0] push_data,
    input  logic               pop,
    output logic [ENTRY_W-1:0] head,
    output q_stat_t            q_stat
);

    logic [ENTRY_W-1:0]  slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head               = slot_reg[rd_ptr_reg];
    assign q_stat.empty       = (count_reg == '0);
    assign q_stat.nearly_full = (count_reg >= QUEUE_CW'(QUEUE_DEPTH - 1));

    `SGSS_ASSERT_IMPLIES(a_no_overflow, push && !pop, count_reg != QUEUE_CW'(QUEUE_DEPTH))
    `SGSS_ASSERT_IMPLIES(a_no_underflow, pop, count_reg != '0)
    `SGSS_ASSERT_ALWAYS(a_count_bound, count_reg <= QUEUE_CW'(QUEUE_DEPTH))

endmodule

// ----- hdl/sgss_back.sv -----
// Back end: accumulator memory with clearing pass, saturating add, read and clear.
// Depends on sgss_pkg and the assertion macro header.
`include "sparse_group_segment_sum_assert.svh"

module sgss_back
    import sgss_pkg::*;
#(
    parameter int ACC_DEPTH = 4096,
    parameter int ACC_AW    = 12,
    parameter int ENTRY_W   = KIND_W + ACC_AW + VALUE_W
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ENTRY_W-1:0] head,
    input  q_stat_t            q_stat,
    output logic               pop,
    output back_stat_t         b_stat,
    output logic               done,
    output res_t               result
);

    typedef struct packed {
        kind_t                     kind;
        logic [ACC_AW-1:0]         index;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    logic [SUM_W:0] acc_mem [ACC_DEPTH];
    logic [SUM_W:0] rd_q_reg;

    state_t            state_reg, state_next;
    logic [ACC_AW-1:0] clr_addr_reg, clr_addr_next;
    entry_t            cur_reg;
    logic              done_reg, done_next;
    res_t              result_reg, result_next;

    entry_t            head_ent;
    logic              wr_en;
    logic [ACC_AW-1:0] wr_addr;
    logic [SUM_W:0]    wr_data;
    logic [SUM_W:0]    total;

    assign head_ent = head;
    assign pop      = (state_reg == ST_IDLE) && !q_stat.empty;

    assign total = {rd_q_reg[SUM_W-1], rd_q_reg[SUM_W-1:0]}
                 + {{(SUM_W + 1 - VALUE_W){cur_reg.value[VALUE_W-1]}}, cur_reg.value};

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        wr_en         = 1'b0;
        wr_addr       = cur_reg.index;
        wr_data       = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ACC_AW'(1);
                if (32'(clr_addr_reg) == ACC_DEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_IDLE;
                case (cur_reg.kind)
                    KIND_ADD:
                    begin
                        wr_en = 1'b1;
                        if (total[SUM_W] != total[SUM_W-1])
                        begin
                            wr_data = {1'b1, total[SUM_W], {(SUM_W - 1){!total[SUM_W]}}};
                        end
                        else
                        begin
                            wr_data = {rd_q_reg[SUM_W], total[SUM_W-1:0]};
                        end
                    end
                    KIND_READ:
                    begin
                        wr_en                 = 1'b1;
                        done_next             = 1'b1;
                        result_next.sum       = rd_q_reg[SUM_W-1:0];
                        result_next.saturated = rd_q_reg[SUM_W];
                    end
                    default:
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            acc_mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= acc_mem[head_ent.index];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_ent;
        end
        result_reg <= result_next;
    end

    assign b_stat.clearing = (state_reg == ST_CLEAR);
    assign done            = done_reg;
    assign result          = result_reg;

    `SGSS_ASSERT_IMPLIES(a_no_pop_in_clear, state_reg == ST_CLEAR, !pop)
    `SGSS_ASSERT_IMPLIES(a_apply_after_pop, state_reg == ST_APPLY, $past(pop))
    `SGSS_ASSERT_IMPLIES(a_done_after_apply, done_reg, $past(state_reg == ST_APPLY))

endmodule

// ----- tb/sparse_group_segment_sum_tb.sv -----
// Self-checking testbench for sparse_group_segment_sum: label loads, adds and reads
// are predicted by a behavioral copy of the accumulator tables. Depends on sgss_pkg.
`timescale 1ns / 100ps

module sparse_group_segment_sum_tb;
    import sgss_pkg::*;

    localparam int ROWS   = 4096;
    localparam int GROUPS = 64;
    localparam int COLS   = 64;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 1;

    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 107;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    req_t       request = '0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [6:0] cfg_data = 7'd0;
    logic       done;
    res_t       result;

    // behavioral copy of the block state
    logic [6:0]         row_label [ROWS];
    logic signed [47:0] acc_sum [GROUPS * COLS];
    logic               acc_sat [GROUPS * COLS];
    logic [6:0]         group_limit = 7'd64;

    req_t req_queue [$];
    res_t due_sums [$];
    res_t want;
    int   items_issued = 0;
    int   items_taken = 0;
    int   mismatches = 0;
    bit   calm = 1'b0;

    sparse_group_segment_sum #(
        .MAX_ROWS   (ROWS),
        .MAX_GROUPS (GROUPS),
        .MAX_COLS   (COLS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    always #2 clk = ~clk;

    task automatic apply_request(input req_t r);
        logic [6:0] lab;
        int         limit;
        int         idx;
        longint     s;
        res_t       out;
        case (r.operation)
            OP_LOAD_LABEL:
                row_label[r.row] = r.label;
            OP_ADD:
            begin
                limit = (group_limit > GROUPS) ? GROUPS : int'(group_limit);
                lab = row_label[r.row];
                if (lab >= 1 && int'(lab) <= limit)
                begin
                    idx = (int'(lab) - 1) * COLS + int'(r.column);
                    s = longint'(acc_sum[idx]) + longint'($signed(r.value));
                    if (s > SUM_HI)
                    begin
                        s = SUM_HI;
                        acc_sat[idx] = 1'b1;
                    end
                    else if (s < SUM_LO)
                    begin
                        s = SUM_LO;
                        acc_sat[idx] = 1'b1;
                    end
                    acc_sum[idx] = s[47:0];
                end
            end
            OP_READ:
            begin
                idx = int'(r.group) * COLS + int'(r.column);
                out.sum = acc_sum[idx];
                out.saturated = acc_sat[idx];
                acc_sum[idx] = '0;
                acc_sat[idx] = 1'b0;
                due_sums.push_back(out);
            end
            default:
                ;
        endcase
    endtask

    // driver: one request offered at a time, held until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_request(request);
                items_taken++;
            end
            if (!start || !busy)
            begin
                if (req_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 11))
                begin
                    request <= req_queue.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (due_sums.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got sum %h saturated %b",
                         $time, result.sum, result.saturated);
                mismatches++;
            end
            else
            begin
                want = due_sums.pop_front();
                if (result.sum !== want.sum)
                begin
                    $display("%0t: sum mismatch, expected %h, got %h",
                             $time, want.sum, result.sum);
                    mismatches++;
                end
                if (result.saturated !== want.saturated)
                begin
                    $display("%0t: saturated mismatch, expected %b, got %b",
                             $time, want.saturated, result.saturated);
                    mismatches++;
                end
            end
        end
    end

    function automatic req_t make_req(input logic [1:0] op, input int row, input int col,
                                      input int grp, input int lab, input logic [31:0] val);
        req_t r;
        r.operation = op;
        r.row = 12'(row);
        r.column = 6'(col);
        r.group = 6'(grp);
        r.label = 7'(lab);
        r.value = val;
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            5: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            default: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
        endcase
    endfunction

    task automatic queue_req(input req_t r);
        req_queue.push_back(r);
        items_issued++;
    endtask

    task automatic wait_idle();
        while (items_taken != items_issued || due_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_groups(input logic [6:0] v);
        wait_idle();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        group_limit = v;
    endtask

    task automatic queue_directed();
        queue_req(make_req(OP_LOAD_LABEL, 0, 0, 0, 1, 32'h0));
        queue_req(make_req(OP_LOAD_LABEL, 4095, 63, 63, 64, 32'hFFFF_FFFF));
        queue_req(make_req(OP_LOAD_LABEL, 5, 0, 0, 0, 32'h0));
        queue_req(make_req(OP_LOAD_LABEL, 6, 0, 0, 127, 32'h0));
        queue_req(make_req(OP_ADD, 0, 0, 0, 0, 32'h7FFF_FFFF));
        queue_req(make_req(OP_ADD, 0, 0, 0, 0, 32'h8000_0000));
        queue_req(make_req(OP_ADD, 4095, 63, 0, 0, 32'h8000_0000));
        queue_req(make_req(OP_ADD, 5, 1, 0, 0, 32'd100));
        queue_req(make_req(OP_ADD, 6, 1, 0, 0, 32'd100));
        queue_req(make_req(OP_ADD, 4095, 63, 0, 0, 32'hFFFF_FFFF));
        queue_req(make_req(OP_UNUSED, 4095, 63, 63, 127, 32'hFFFF_FFFF));
        queue_req(make_req(OP_READ, 0, 0, 0, 0, 32'h0));
        queue_req(make_req(OP_READ, 0, 0, 0, 0, 32'h0));
        queue_req(make_req(OP_READ, 0, 63, 63, 0, 32'h0));
        queue_req(make_req(OP_READ, 0, 63, 63, 0, 32'h0));
        // back-to-back adds into one accumulator, then read right behind them
        queue_req(make_req(OP_ADD, 0, 2, 0, 0, 32'd5));
        queue_req(make_req(OP_ADD, 0, 2, 0, 0, 32'd7));
        queue_req(make_req(OP_ADD, 0, 2, 0, 0, 32'd9));
        queue_req(make_req(OP_READ, 0, 2, 0, 0, 32'h0));
        queue_req(make_req(OP_READ, 0, 0, 63, 0, 32'h0));
        // relabel, add, read, add behind the clear, read again
        queue_req(make_req(OP_LOAD_LABEL, 0, 0, 0, 2, 32'h0));
        queue_req(make_req(OP_ADD, 0, 2, 0, 0, 32'd3));
        queue_req(make_req(OP_READ, 0, 2, 1, 0, 32'h0));
        queue_req(make_req(OP_ADD, 0, 2, 0, 0, 32'd4));
        queue_req(make_req(OP_READ, 0, 2, 1, 0, 32'h0));
    endtask

    function automatic int pick_label();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(1, 8);
        return $urandom_range(0, 127);
    endfunction

    // one matrix: a small working set of rows and columns, mostly well-formed traffic
    task automatic queue_matrix(input int n);
        int   wrow [8];
        int   wlab [8];
        int   wcol [4];
        int   k;
        int   pick;
        req_t r;
        for (int i = 0; i < 4; i++)
            wcol[i] = $urandom_range(0, COLS - 1);
        for (int i = 0; i < 8; i++)
        begin
            wrow[i] = $urandom_range(0, ROWS - 1);
            wlab[i] = pick_label();
            queue_req(make_req(OP_LOAD_LABEL, wrow[i], $urandom_range(0, 63),
                               $urandom_range(0, 63), wlab[i], $urandom));
        end
        for (int i = 0; i < n; i++)
        begin
            r.row = 12'($urandom);
            r.column = 6'($urandom);
            r.group = 6'($urandom);
            r.label = 7'($urandom);
            r.value = $urandom;
            k = $urandom_range(0, 7);
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                r.operation = OP_LOAD_LABEL;
                if ($urandom_range(0, 3) != 0)
                begin
                    r.row = 12'(wrow[k]);
                    wlab[k] = pick_label();
                    r.label = 7'(wlab[k]);
                end
                else
                begin
                    for (int j = 0; j < 8; j++)
                        if (wrow[j] == int'(r.row))
                            wlab[j] = int'(r.label);
                end
            end
            else if (pick < 65)
            begin
                r.operation = OP_ADD;
                r.row = 12'(wrow[k]);
                if ($urandom_range(0, 4) != 0)
                    r.column = 6'(wcol[$urandom_range(0, 3)]);
                r.value = pick_value();
            end
            else if (pick < 95)
            begin
                r.operation = OP_READ;
                if ($urandom_range(0, 3) != 0)
                begin
                    if (wlab[k] != 0)
                        r.group = 6'(wlab[k] - 1);
                    r.column = 6'(wcol[$urandom_range(0, 3)]);
                end
            end
            else
                r.operation = OP_UNUSED;
            queue_req(r);
        end
    endtask

    initial
    begin
        logic [6:0] limits [8];
        limits = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd32, 7'd2, 7'd63, 7'd64};
        for (int i = 0; i < ROWS; i++)
            row_label[i] = '0;
        for (int i = 0; i < GROUPS * COLS; i++)
        begin
            acc_sum[i] = '0;
            acc_sat[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);

        queue_directed();
        for (int k = 0; k < 8; k++)
        begin
            if (k == 4 || k == 5)
                limits[k] = 7'($urandom_range(2, 63));
            write_groups(limits[k]);
            calm = (k == 3);
            queue_matrix(PHASE_ITEMS);
        end
        wait_idle();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
